FILE: src/wmo_hp_pkg.sv
// ----------------------------------------------------------------------------
// WMO heading parser package
// Character codes, token geometry, character class helpers and the summary
// structures passed between the scanner blocks and the top level.
// ----------------------------------------------------------------------------
package wmo_hp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Token widths of the first line scan: designator, station, time, bbb.
  localparam logic [2:0] ID_LEN  = 3'd6;
  localparam logic [2:0] STN_LEN = 3'd4;
  localparam logic [2:0] DTG_LEN = 3'd6;
  localparam logic [2:0] BBB_LEN = 3'd6;

  // Number of tokens scanned for each accepted blank count.
  localparam logic [2:0] BLANKS_SHORT = 3'd2;
  localparam logic [2:0] BLANKS_LONG  = 3'd3;
  localparam logic [2:0] BLANKS_SAT   = 3'd4;
  localparam logic [2:0] NEED_NONE    = 3'd0;
  localparam logic [2:0] NEED_SHORT   = 3'd3;
  localparam logic [2:0] NEED_LONG    = 3'd4;
  localparam logic [2:0] TOK_DONE     = 3'd4;

  // Token slots.
  localparam logic [1:0] TOK_ID  = 2'd0;
  localparam logic [1:0] TOK_STN = 2'd1;
  localparam logic [1:0] TOK_DTG = 2'd2;
  localparam logic [1:0] TOK_BBB = 2'd3;

  // Second line: an AWIPS line carries its newline at this offset.
  localparam logic [3:0] AWIPS_NL_OFFSET = 4'd8;
  localparam logic [3:0] LINE2_OFF_SAT   = 4'd9;
  localparam logic [3:0] LINE2_CODE_LEN  = 4'd6;

  typedef struct packed {
    logic en;      // byte lands inside the buffer
    logic fin;     // this byte is the last one; state returns to idle after it
    logic at_end;  // byte sits in the final buffer position
  } step_ctl_t;

  typedef struct packed {
    logic        ok;
    logic [47:0] heading_id;
    logic [31:0] station;
    logic [47:0] day_time;
    logic [47:0] bbb_code;
  } first_sum_t;

  typedef struct packed {
    logic        has_line;
    logic        alpha_start;
    logic        awips_form;
    logic [47:0] awips;
    logic [47:0] other;
  } line2_sum_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic [2:0] tok_width(input logic [1:0] idx);
    logic [2:0] w;
    case (idx)
      TOK_ID:  w = ID_LEN;
      TOK_STN: w = STN_LEN;
      TOK_DTG: w = DTG_LEN;
      default: w = BBB_LEN;
    endcase
    return w;
  endfunction

  // Character class that each token slot must satisfy.
  function automatic logic tok_class_ok(input logic [1:0] idx, input logic [7:0] c);
    logic ok;
    case (idx)
      TOK_STN: ok = is_alpha(c);
      TOK_DTG: ok = is_digit(c);
      default: ok = is_alnum(c);
    endcase
    return ok;
  endfunction

endpackage

FILE: src/wmo_hp_in_if.sv
// ----------------------------------------------------------------------------
// WMO heading parser input channel
// One header byte per beat with a flag on the final byte.
// ----------------------------------------------------------------------------
interface wmo_hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last;

  modport source (output valid, output byte_in, output last, input ready);
  modport sink (input valid, input byte_in, input last, output ready);
endinterface

FILE: src/wmo_hp_out_if.sv
// ----------------------------------------------------------------------------
// WMO heading parser result channel
// One parsed heading per beat.
// ----------------------------------------------------------------------------
interface wmo_hp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [47:0] heading_id;
  logic [31:0] station;
  logic [47:0] day_time;
  logic [47:0] bbb_code;
  logic [47:0] awips_code;
  logic [47:0] other_code;

  modport source (output valid, output status, output heading_id, output station,
                  output day_time, output bbb_code, output awips_code,
                  output other_code, input ready);
  modport sink (input valid, input status, input heading_id, input station,
                input day_time, input bbb_code, input awips_code,
                input other_code, output ready);
endinterface

FILE: src/wmo_hp_first.sv
// ----------------------------------------------------------------------------
// WMO heading parser first line scanner
// Counts blanks on the first line and splits the heading tokens on the fly.
// ----------------------------------------------------------------------------
module wmo_hp_first (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wmo_hp_pkg::step_ctl_t  ctl,
  input  logic [7:0]             byte_in,
  output wmo_hp_pkg::first_sum_t sum
);

  logic        line_open_r, line_open_nxt;
  logic [2:0]  blanks_r, blanks_nxt;
  logic [2:0]  tok_num_r, tok_num_nxt;
  logic        in_tok_r, in_tok_nxt;
  logic        ended_r, ended_nxt;
  logic [2:0]  len_r [4];
  logic [2:0]  len_nxt [4];
  logic [3:0]  cls_r, cls_nxt;
  logic [47:0] id_r, id_nxt;
  logic [31:0] stn_r, stn_nxt;
  logic [47:0] dtg_r, dtg_nxt;
  logic [47:0] bbb_r, bbb_nxt;

  logic       ws, zero, append, finish;
  logic [1:0] tsel;
  logic [2:0] cur_len, new_len, need, started;

  always_comb begin
    line_open_nxt = line_open_r;
    blanks_nxt    = blanks_r;
    tok_num_nxt   = tok_num_r;
    in_tok_nxt    = in_tok_r;
    ended_nxt     = ended_r;
    len_nxt       = len_r;
    cls_nxt       = cls_r;
    id_nxt        = id_r;
    stn_nxt       = stn_r;
    dtg_nxt       = dtg_r;
    bbb_nxt       = bbb_r;
    append        = 1'b0;
    finish        = 1'b0;

    ws      = wmo_hp_pkg::is_ws(byte_in);
    zero    = (byte_in == wmo_hp_pkg::CH_NUL);
    tsel    = tok_num_r[1:0];
    cur_len = len_r[tsel];
    new_len = cur_len + 3'd1;

    if (ctl.en) begin
      if (line_open_r) begin
        if ((byte_in == wmo_hp_pkg::CH_NL) || zero) begin
          line_open_nxt = 1'b0;
        end else if ((byte_in == wmo_hp_pkg::CH_SPACE) &&
                     (blanks_r != wmo_hp_pkg::BLANKS_SAT)) begin
          blanks_nxt = blanks_r + 3'd1;
        end
      end
      if (!ended_r && (tok_num_r != wmo_hp_pkg::TOK_DONE)) begin
        if (!in_tok_r) begin
          if (zero) begin
            ended_nxt = 1'b1;
          end else if (!ws) begin
            append = 1'b1;
          end
        end else begin
          if (zero) begin
            finish    = 1'b1;
            ended_nxt = 1'b1;
          end else if (ws) begin
            finish = 1'b1;
          end else begin
            append = 1'b1;
          end
        end
      end
    end

    if (append) begin
      len_nxt[tsel] = new_len;
      cls_nxt[tsel] = cls_r[tsel] & wmo_hp_pkg::tok_class_ok(tsel, byte_in);
      in_tok_nxt    = 1'b1;
      case (tsel)
        wmo_hp_pkg::TOK_ID:  id_nxt  = {id_r[39:0], byte_in};
        wmo_hp_pkg::TOK_STN: stn_nxt = {stn_r[23:0], byte_in};
        wmo_hp_pkg::TOK_DTG: dtg_nxt = {dtg_r[39:0], byte_in};
        default: begin
          for (int k = 0; k < 6; k++) begin
            if (cur_len == 3'(k)) begin
              bbb_nxt[47-8*k -: 8] = byte_in;
            end
          end
        end
      endcase
      // A token is cut as soon as it reaches its width.
      if (new_len == wmo_hp_pkg::tok_width(tsel)) begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      tok_num_nxt = tok_num_r + 3'd1;
      in_tok_nxt  = 1'b0;
    end
  end

  // Bytes past the end of the supplied data read as zero, so an open token
  // closes there and counts as found.
  always_comb begin
    case (blanks_nxt)
      wmo_hp_pkg::BLANKS_SHORT: need = wmo_hp_pkg::NEED_SHORT;
      wmo_hp_pkg::BLANKS_LONG:  need = wmo_hp_pkg::NEED_LONG;
      default:                  need = wmo_hp_pkg::NEED_NONE;
    endcase
    started = tok_num_nxt + {2'b00, in_tok_nxt};

    sum.ok = (need != wmo_hp_pkg::NEED_NONE) && (started >= need) &&
             (len_nxt[wmo_hp_pkg::TOK_ID] == wmo_hp_pkg::ID_LEN) &&
             (len_nxt[wmo_hp_pkg::TOK_STN] == wmo_hp_pkg::STN_LEN) &&
             (len_nxt[wmo_hp_pkg::TOK_DTG] == wmo_hp_pkg::DTG_LEN) &&
             cls_nxt[wmo_hp_pkg::TOK_ID] && cls_nxt[wmo_hp_pkg::TOK_STN] &&
             cls_nxt[wmo_hp_pkg::TOK_DTG] &&
             ((need == wmo_hp_pkg::NEED_SHORT) || cls_nxt[wmo_hp_pkg::TOK_BBB]);
    sum.heading_id = id_nxt;
    sum.station    = stn_nxt;
    sum.day_time   = dtg_nxt;
    sum.bbb_code   = (need == wmo_hp_pkg::NEED_LONG) ? bbb_nxt : 48'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.fin) begin
      line_open_r <= 1'b1;
      blanks_r    <= '0;
      tok_num_r   <= '0;
      in_tok_r    <= 1'b0;
      ended_r     <= 1'b0;
      cls_r       <= '1;
      bbb_r       <= '0;
      for (int k = 0; k < 4; k++) begin
        len_r[k] <= '0;
      end
    end else begin
      line_open_r <= line_open_nxt;
      blanks_r    <= blanks_nxt;
      tok_num_r   <= tok_num_nxt;
      in_tok_r    <= in_tok_nxt;
      ended_r     <= ended_nxt;
      cls_r       <= cls_nxt;
      bbb_r       <= bbb_nxt;
      len_r       <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    stn_r <= stn_nxt;
    dtg_r <= dtg_nxt;
  end

endmodule

FILE: src/wmo_hp_line2.sv
// ----------------------------------------------------------------------------
// WMO heading parser second line scanner
// Finds the first newline and collects the AWIPS and alphanumeric candidates.
// ----------------------------------------------------------------------------
module wmo_hp_line2 (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wmo_hp_pkg::step_ctl_t  ctl,
  input  logic [7:0]             byte_in,
  output wmo_hp_pkg::line2_sum_t sum
);

  logic        nl_seen_r, nl_seen_nxt;
  logic        nl_last_r, nl_last_nxt;
  logic [3:0]  off_r, off_nxt;
  logic        alpha_r, alpha_nxt;
  logic        nl8_r, nl8_nxt;
  logic        aw_run_r, aw_run_nxt;
  logic        ot_run_r, ot_run_nxt;
  logic [47:0] aw_r, aw_nxt;
  logic [47:0] ot_r, ot_nxt;

  logic ws, zero;

  always_comb begin
    nl_seen_nxt = nl_seen_r;
    nl_last_nxt = nl_last_r;
    off_nxt     = off_r;
    alpha_nxt   = alpha_r;
    nl8_nxt     = nl8_r;
    aw_run_nxt  = aw_run_r;
    ot_run_nxt  = ot_run_r;
    aw_nxt      = aw_r;
    ot_nxt      = ot_r;

    ws   = wmo_hp_pkg::is_ws(byte_in);
    zero = (byte_in == wmo_hp_pkg::CH_NUL);

    if (ctl.en) begin
      if (!nl_seen_r) begin
        if (byte_in == wmo_hp_pkg::CH_NL) begin
          nl_seen_nxt = 1'b1;
          nl_last_nxt = ctl.at_end;
          off_nxt     = '0;
          aw_run_nxt  = 1'b1;
          ot_run_nxt  = 1'b1;
        end
      end else begin
        if (off_r != wmo_hp_pkg::LINE2_OFF_SAT) begin
          off_nxt = off_r + 4'd1;
        end
        if (off_r == 4'd0) begin
          alpha_nxt = wmo_hp_pkg::is_alpha(byte_in);
        end
        if (off_r == wmo_hp_pkg::AWIPS_NL_OFFSET) begin
          nl8_nxt = (byte_in == wmo_hp_pkg::CH_NL);
        end
        if (off_r < wmo_hp_pkg::LINE2_CODE_LEN) begin
          if (aw_run_r && !ws && !zero) begin
            for (int k = 0; k < 6; k++) begin
              if (off_r == 4'(k)) begin
                aw_nxt[47-8*k -: 8] = byte_in;
              end
            end
          end else begin
            aw_run_nxt = 1'b0;
          end
          if (ot_run_r && wmo_hp_pkg::is_alnum(byte_in)) begin
            for (int k = 0; k < 6; k++) begin
              if (off_r == 4'(k)) begin
                ot_nxt[47-8*k -: 8] = byte_in;
              end
            end
          end else begin
            ot_run_nxt = 1'b0;
          end
        end
      end
    end

    // A newline in the final position leaves no second line at all.
    sum.has_line    = nl_seen_nxt && !nl_last_nxt;
    sum.alpha_start = alpha_nxt;
    sum.awips_form  = nl8_nxt;
    sum.awips       = aw_nxt;
    sum.other       = ot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.fin) begin
      nl_seen_r <= 1'b0;
      nl_last_r <= 1'b0;
      off_r     <= '0;
      alpha_r   <= 1'b0;
      nl8_r     <= 1'b0;
      aw_run_r  <= 1'b0;
      ot_run_r  <= 1'b0;
      aw_r      <= '0;
      ot_r      <= '0;
    end else begin
      nl_seen_r <= nl_seen_nxt;
      nl_last_r <= nl_last_nxt;
      off_r     <= off_nxt;
      alpha_r   <= alpha_nxt;
      nl8_r     <= nl8_nxt;
      aw_run_r  <= aw_run_nxt;
      ot_run_r  <= ot_run_nxt;
      aw_r      <= aw_nxt;
      ot_r      <= ot_nxt;
    end
  end

endmodule

FILE: src/wmo_heading_parser_unit.sv
// ----------------------------------------------------------------------------
// WMO abbreviated heading parser
// Streams the bytes of a product header and emits one parsed heading per
// header on its final byte.
// ----------------------------------------------------------------------------
// The last byte passes the input register and then the result register, which holds the result beat.
// The parser takes one byte per cycle except during the stall below.
// The only stall is a last byte waiting behind an unconsumed result beat.
// Reset (rst_n low, synchronous) clears the scanners, the position counter
// and both valid flags; scanners also return to idle after every result.
// ----------------------------------------------------------------------------
module wmo_heading_parser_unit #(
  parameter int unsigned BUFFER_BYTES = 128
) (
  input logic            clk,
  input logic            rst_n,
  wmo_hp_in_if.sink      in_if,
  wmo_hp_out_if.source   out_if
);

  localparam int unsigned PosW = $clog2(BUFFER_BYTES + 1);

  // Input register: one byte beat held for the scanners.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       adv;

  // Number of bytes stored in the current header, saturating at the buffer
  // size. Bytes beyond the buffer are consumed but never scanned.
  logic [PosW-1:0] pos_r, pos_nxt;

  wmo_hp_pkg::step_ctl_t  ctl;
  wmo_hp_pkg::first_sum_t first_sum;
  wmo_hp_pkg::line2_sum_t line2_sum;

  // Result register.
  logic        out_valid_r;
  logic        status_r;
  logic [47:0] heading_id_r, station_ext, day_time_r, bbb_code_r;
  logic [31:0] station_r;
  logic [47:0] awips_code_r, other_code_r;
  logic [47:0] awips_nxt, other_nxt;

  // The held byte moves on unless it is a last byte and the result register
  // still holds a beat that is not taken in this cycle.
  assign adv         = s1_valid_r && (!s1_last_r || !out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_byte_r <= in_if.byte_in;
      s1_last_r <= in_if.last;
    end
  end

  always_comb begin
    ctl.en     = adv && (pos_r < PosW'(BUFFER_BYTES));
    ctl.fin    = adv && s1_last_r;
    ctl.at_end = (pos_r == PosW'(BUFFER_BYTES - 1));
    pos_nxt    = pos_r;
    if (ctl.fin) begin
      pos_nxt = '0;
    end else if (ctl.en) begin
      pos_nxt = pos_r + PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // First line: blank count, token split and token checks.
  wmo_hp_first u_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .byte_in (s1_byte_r),
    .sum     (first_sum)
  );

  // Second line: newline search and code candidates.
  wmo_hp_line2 u_line2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .byte_in (s1_byte_r),
    .sum     (line2_sum)
  );

  // Second line selection. With no second line both codes stay zero. A line
  // that does not open with a letter hands the bbb token to other_code. An
  // AWIPS line (newline at offset eight) fills awips_code only; any other
  // line fills other_code with its leading alphanumeric run.
  always_comb begin
    awips_nxt = '0;
    other_nxt = '0;
    if (line2_sum.has_line) begin
      if (!line2_sum.alpha_start) begin
        other_nxt = first_sum.bbb_code;
      end else if (line2_sum.awips_form) begin
        awips_nxt = line2_sum.awips;
      end else begin
        other_nxt = line2_sum.other;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // A malformed heading reports status one with every text field zero.
  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      status_r     <= !first_sum.ok;
      heading_id_r <= first_sum.ok ? first_sum.heading_id : 48'd0;
      station_r    <= first_sum.ok ? first_sum.station : 32'd0;
      day_time_r   <= first_sum.ok ? first_sum.day_time : 48'd0;
      bbb_code_r   <= first_sum.ok ? first_sum.bbb_code : 48'd0;
      awips_code_r <= first_sum.ok ? awips_nxt : 48'd0;
      other_code_r <= first_sum.ok ? other_nxt : 48'd0;
    end
  end

  assign station_ext = {16'd0, station_r};

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = status_r;
  assign out_if.heading_id = heading_id_r;
  assign out_if.station    = station_r;
  assign out_if.day_time   = day_time_r;
  assign out_if.bbb_code   = bbb_code_r;
  assign out_if.awips_code = awips_code_r;
  assign out_if.other_code = other_code_r;

  // A result beat only ever starts from a final byte leaving the input register.
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && s1_last_r))
    else $error("result beat raised without a final byte");

  // A malformed heading carries no text.
  a_malformed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |->
      ((heading_id_r == 48'd0) && (station_ext == 48'd0) && (day_time_r == 48'd0) &&
       (bbb_code_r == 48'd0) && (awips_code_r == 48'd0) && (other_code_r == 48'd0)))
    else $error("malformed heading carries text");

  // The position counter restarts for the next header after a final byte.
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin |=> (pos_r == '0))
    else $error("position counter did not restart");

  // A final byte stuck behind an untaken result blocks new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_valid_r && !out_if.ready) |=> $stable(s1_byte_r))
    else $error("held final byte overwritten during stall");

endmodule
